// ----- rtl/lir_pkg.sv -----
// Shared types and constants of the linear interpolation resampler.
`default_nettype none

package lir_pkg;

    // Fixed widths of the stream and configuration words
    localparam int SAMPLE_BITS   = 16;
    localparam int STEP_BITS     = 21;
    localparam int FRAC_BITS_DEF = 16;

    // Input word: one sample plus end marker
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic                          last_sample;
    } t_in_word;

    // Output word: one interpolated sample plus end flag
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic                          end_of_signal;
    } t_out_word;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SEG1,
        S_CHECK,
        S_MUL,
        S_EMIT,
        S_WRAP
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic setup_seg1;
        logic setup_seg2;
        logic mul;
        logic emit;
        logic wrap;
        logic finish_plain;
        logic finish_last;
        logic cfg_ok;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic have_prev;
        logic in_last;
        logic pos_lt_one;
        logic seg2;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

// ----- rtl/lir_ctrl.sv -----
// Sequencer of the resampler: walks the intervals of one input word.
`default_nettype none

module lir_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_stall,
    input  lir_pkg::t_dp_stat  i_stat,
    output lir_pkg::t_dp_cmd   o_cmd
);
    import lir_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                // step may change only while no word is arriving
                o_cmd.cfg_ok = !i_in_valid;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_SEG1;
                end
            end
            S_SEG1: begin
                // first interval runs only once a previous sample exists
                if (i_stat.have_prev) begin
                    o_cmd.setup_seg1 = 1'b1;
                    n_state          = S_CHECK;
                end else if (i_stat.in_last) begin
                    o_cmd.setup_seg2 = 1'b1;
                    n_state          = S_CHECK;
                end else begin
                    o_cmd.finish_plain = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            S_CHECK: begin
                if (i_stat.pos_lt_one) begin
                    n_state = S_MUL;
                end else begin
                    n_state = S_WRAP;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_EMIT;
            end
            S_EMIT: begin
                // wait for the output register to free up
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_WRAP: begin
                o_cmd.wrap = 1'b1;
                if (!i_stat.seg2 && i_stat.in_last) begin
                    o_cmd.setup_seg2 = 1'b1;
                    n_state          = S_CHECK;
                end else if (i_stat.seg2) begin
                    o_cmd.finish_last = 1'b1;
                    n_state           = S_IDLE;
                end else begin
                    o_cmd.finish_plain = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Checks
    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |=> (r_state == S_EMIT))
        else $error("multiply not followed by emit");
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_stat.out_free)
        else $error("emit into a busy output register");
    a_capture_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> (r_state == S_SEG1 && o_in_stall))
        else $error("capture did not start an item");

endmodule

`default_nettype wire

// ----- rtl/lir_datapath.sv -----
// Datapath of the resampler: position, sample registers, multiplier, output register.
`default_nettype none

module lir_datapath #(
    parameter int FRAC_BITS = lir_pkg::FRAC_BITS_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  lir_pkg::t_dp_cmd                     i_cmd,
    output lir_pkg::t_dp_stat                    o_stat,
    input  lir_pkg::t_in_word                    i_in_word,
    output logic                                 o_out_valid,
    input  wire                                  i_out_stall,
    output lir_pkg::t_out_word                   o_out_word,
    input  wire                                  i_cfg_valid,
    input  wire  [lir_pkg::STEP_BITS-1:0]        i_cfg_data,
    output logic                                 o_cfg_ready
);
    import lir_pkg::*;

    // Position holds below 1.0 plus one step; 2.0 must be comparable
    localparam int MAXW   = (FRAC_BITS > STEP_BITS) ? FRAC_BITS : STEP_BITS;
    localparam int POS_W  = MAXW + 2;
    localparam int DIFF_W = SAMPLE_BITS + 1;
    localparam int PROD_W = DIFF_W + FRAC_BITS + 1;
    localparam logic [POS_W-1:0] ONE      = POS_W'(1) << FRAC_BITS;
    localparam logic [POS_W-1:0] TWO      = POS_W'(2) << FRAC_BITS;
    localparam logic [POS_W-1:0] MIN_STEP = POS_W'(1) << (FRAC_BITS - 5);
    localparam logic [POS_W-1:0] POS_LIM  = ONE + (POS_W'(1) << STEP_BITS);

    logic        [STEP_BITS-1:0]   r_step;
    logic signed [SAMPLE_BITS-1:0] r_in_sample;
    logic                          r_in_last;
    logic signed [SAMPLE_BITS-1:0] r_prev;
    logic                          r_have;
    logic        [POS_W-1:0]       r_pos;
    logic signed [SAMPLE_BITS-1:0] r_x0;
    logic signed [SAMPLE_BITS-1:0] r_x1;
    logic                          r_seg2;
    logic signed [PROD_W-1:0]      r_prod;
    logic                          r_flag;
    t_out_word                     r_out_word;
    logic                          r_out_valid;

    logic        [POS_W-1:0]       w_step_eff;
    logic        [POS_W-1:0]       w_pos_nxt;
    logic signed [DIFF_W-1:0]      w_diff;
    logic signed [FRAC_BITS:0]     w_frac;
    logic signed [PROD_W-1:0]      w_shift;
    logic signed [PROD_W-1:0]      w_sum;

    // Step clamped to 1/32 so one interval gives at most 32 words
    assign w_step_eff = (POS_W'(r_step) < MIN_STEP) ? MIN_STEP : POS_W'(r_step);
    assign w_pos_nxt  = r_pos + w_step_eff;

    // x0 + floor((x1 - x0) * frac / 2^FRAC_BITS)
    assign w_diff  = DIFF_W'(r_x1) - DIFF_W'(r_x0);
    assign w_frac  = $signed({1'b0, r_pos[FRAC_BITS-1:0]});
    assign w_shift = r_prod >>> FRAC_BITS;
    assign w_sum   = PROD_W'(r_x0) + w_shift;

    // Step register, written only between items
    assign o_cfg_ready = i_cmd.cfg_ok;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_BITS'(ONE);
        end else if (i_cfg_valid && i_cmd.cfg_ok) begin
            r_step <= i_cfg_data;
        end
    end

    // Captured input word and interval endpoints
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in_sample <= i_in_word.sample_in;
            r_in_last   <= i_in_word.last_sample;
        end
        if (i_cmd.setup_seg1) begin
            r_x0   <= r_prev;
            r_x1   <= r_in_sample;
            r_seg2 <= 1'b0;
        end else if (i_cmd.setup_seg2) begin
            r_x0   <= r_in_sample;
            r_x1   <= '0;
            r_seg2 <= 1'b1;
        end
        // flag: this word is the last one the item produces
        if (i_cmd.mul) begin
            r_prod <= w_diff * w_frac;
            r_flag <= r_in_last && (r_seg2 ? (w_pos_nxt >= ONE) : (w_pos_nxt >= TWO));
        end
    end

    // Previous sample, position and history flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_have <= 1'b0;
            r_pos  <= '0;
        end else if (i_cmd.finish_last) begin
            r_prev <= '0;
            r_have <= 1'b0;
            r_pos  <= '0;
        end else begin
            if (i_cmd.finish_plain) begin
                r_prev <= r_in_sample;
                r_have <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_pos <= w_pos_nxt;
            end else if (i_cmd.wrap) begin
                r_pos <= r_pos - ONE;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_word.sample_out    <= w_sum[SAMPLE_BITS-1:0];
            r_out_word.end_of_signal <= r_flag;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // Status to the sequencer
    assign o_stat.have_prev  = r_have;
    assign o_stat.in_last    = r_in_last;
    assign o_stat.pos_lt_one = (r_pos < ONE);
    assign o_stat.seg2       = r_seg2;
    assign o_stat.out_free   = !r_out_valid || !i_out_stall;

    // Checks
    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> o_out_valid)
        else $error("emitted word not presented");
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish_last |=> (r_pos == '0 && !r_have && r_prev == '0))
        else $error("state not cleared after last sample");
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos < POS_LIM)
        else $error("position out of range");

endmodule

`default_nettype wire

// ----- rtl/linear_interp_resampler.sv -----
// Each accepted item is worked through by the sequencer; a new item is taken
// only once the sequencer is back in idle. Each output word passes through the
// check, multiply and emit states; an output stall holds the emit state. A plain
// first sample, with no stored previous sample, produces no output word.
// Reset: synchronous active low; clears history, position and output valid,
// step returns to 1.0.
`default_nettype none

module linear_interp_resampler #(
    parameter int FRAC_BITS = lir_pkg::FRAC_BITS_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_in_valid,
    output logic                           o_in_stall,
    input  lir_pkg::t_in_word              i_in_word,
    output logic                           o_out_valid,
    input  wire                            i_out_stall,
    output lir_pkg::t_out_word             o_out_word,
    input  wire                            i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire  [lir_pkg::STEP_BITS-1:0]  i_cfg_data
);
    import lir_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // Sequencer
    lir_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Datapath
    lir_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready)
    );

endmodule

`default_nettype wire
